>>> sv/sod_pkg.sv
// ----------------------------------------------------------------------------
// sod_pkg: shared types and constants for the segment offset densifier
// Beat structs, sequencer states, outcome codes and register indexes.
// ----------------------------------------------------------------------------
package sod_pkg;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
	} sod_in_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic [1:0]         outcome;
		logic               last_point;
	} sod_out_t;

	localparam logic [1:0] OUT_NORMAL = 2'd0;
	localparam logic [1:0] OUT_NONE   = 2'd1;
	localparam logic [1:0] OUT_CAPPED = 2'd2;

	localparam logic REG_OFFSET = 1'b0;
	localparam logic REG_MINLEN = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQRT,
		ST_CHECK,
		ST_OFFX_MUL,
		ST_OFFX_DIV,
		ST_OFFY_MUL,
		ST_OFFY_DIV,
		ST_CNT_DIV,
		ST_STEPX_DIV,
		ST_STEPY_DIV,
		ST_EMIT,
		ST_NONE
	} sod_state_t;

	// Divider request
	typedef struct packed {
		logic        start;
		logic [65:0] num;
		logic [63:0] den;
	} sod_div_req_t;

	typedef struct packed {
		logic        done;
		logic [65:0] quo;
	} sod_div_rsp_t;

endpackage

>>> sv/sod_divider.sv
// ----------------------------------------------------------------------------
// sod_divider: shared restoring divider
// Unsigned 66-bit by 64-bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sod_divider
	import sod_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  sod_div_req_t req,
	output sod_div_rsp_t rsp
);

	logic [65:0] quo_q;
	logic [64:0] rem_q;
	logic [63:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [65:0] trial;

	// Shift one numerator bit into the partial remainder and try a subtract
	assign trial = {rem_q, quo_q[65]} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd66;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[65]) begin
				rem_q <= trial[64:0];
				quo_q <= {quo_q[64:0], 1'b1};
			end else begin
				rem_q <= {rem_q[63:0], quo_q[65]};
				quo_q <= {quo_q[64:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

>>> sv/sod_isqrt.sv
// ----------------------------------------------------------------------------
// sod_isqrt: digit-by-digit integer square root
// Floor root of a 66-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module sod_isqrt
	import sod_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [65:0] radicand,
	output logic        done,
	output logic [32:0] root
);

	logic [65:0] val_q;
	logic [35:0] rem_q;
	logic [32:0] root_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [35:0] rem_sh;
	logic [35:0] trial;

	// Bring down two radicand bits, test (4*root+1)
	assign rem_sh = {rem_q[33:0], val_q[65:64]};
	assign trial  = rem_sh - {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[63:0], 2'b00};
			if (!trial[35]) begin
				rem_q  <= trial;
				root_q <= {root_q[31:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[31:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> sv/segment_offset_densifier_core.sv
// ----------------------------------------------------------------------------
// segment_offset_densifier_core: offset a segment sideways and densify it
// Computes length, left-normal offset and step, then emits evenly spaced points.
// ----------------------------------------------------------------------------
// Sequence: length stage (two squares, digit-by-digit root), then five divides on
// the shared divider, a multiply state before each of the first two; then the
// points follow, one point per cycle. A new segment is taken only in idle; a
// degenerate segment gives its single no-output beat in place of points.
// Results are one-cycle strobes; the receiver cannot stall.
// Reset: async, active low; offset 0.
module segment_offset_densifier_core
	import sod_pkg::*;
#(
	parameter int MAX_SEGMENTS = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  sod_in_t     in_beat,
	output logic        result_valid,
	output sod_out_t    result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = $clog2(MAX_SEGMENTS + 1);

	// Configuration registers
	logic signed [31:0] offset_q;
	logic signed [31:0] minlen_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= 32'sd0;
			minlen_q <= 32'sd65536;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == REG_OFFSET)
			offset_q <= pwdata;
		else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == REG_MINLEN)
			minlen_q <= pwdata;
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[1:0] == 2'b00)
			prdata = (paddr[2] == REG_OFFSET) ? offset_q : minlen_q;
	end

	// Sequencer and datapath registers
	sod_state_t state_q, state_d;
	logic signed [32:0] dx_q, dy_q;
	logic signed [31:0] sx_q, sy_q;
	logic [32:0]        len_q;
	logic [63:0]        prod_q;
	logic signed [33:0] offx_q, offy_q;
	logic [CW-1:0]      ns_q, idx_q;
	logic               cap_q;
	logic signed [33:0] stx_q, sty_q;
	logic signed [40:0] accx_q, accy_q;

	logic [31:0] ax, ay, ad;
	logic        sq_done;
	logic [32:0] sq_root;
	sod_div_req_t dreq;
	sod_div_rsp_t drsp;

	assign ax = dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
	assign ay = dy_q[32] ? 32'(-dy_q) : dy_q[31:0];
	assign ad = offset_q[31] ? 32'(-offset_q) : offset_q;

	// Sum of squares, built from ax*ax then ay*ay on the shared multiplier
	logic [64:0] sumsq_q;

	logic sq_go;
	sod_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_go),
		.radicand({1'b0, sumsq_q}), .done(sq_done), .root(sq_root)
	);

	sod_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// Shared multiplier: operands chosen by state
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [1:0]  phase_q;
	always_comb begin
		mul_a = ax;
		mul_b = ax;
		unique case (state_q)
			ST_OFFX_MUL: begin mul_a = ay; mul_b = ad; end
			ST_OFFY_MUL: begin mul_a = ax; mul_b = ad; end
			default: begin
				mul_a = (phase_q == 2'd0) ? ax : ay;
				mul_b = mul_a;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	logic degen;
	assign degen = (minlen_q <= 0) || (len_q == 33'd0);

	logic [32:0] ns_full;
	assign ns_full = drsp.quo[32:0];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (start) state_d = ST_SQRT;
			ST_SQRT:      if (sq_done) state_d = ST_CHECK;
			ST_CHECK:     state_d = degen ? ST_NONE : ST_OFFX_MUL;
			ST_OFFX_MUL:  state_d = ST_OFFX_DIV;
			ST_OFFX_DIV:  if (drsp.done) state_d = ST_OFFY_MUL;
			ST_OFFY_MUL:  state_d = ST_OFFY_DIV;
			ST_OFFY_DIV:  if (drsp.done) state_d = ST_CNT_DIV;
			ST_CNT_DIV:   if (drsp.done) state_d = ST_STEPX_DIV;
			ST_STEPX_DIV: if (drsp.done) state_d = ST_STEPY_DIV;
			ST_STEPY_DIV: if (drsp.done) state_d = ST_EMIT;
			ST_EMIT:      if (idx_q == ns_q) state_d = ST_IDLE;
			ST_NONE:      state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Divider launches: on entry to each divide state
	logic div_pend_q;
	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = '0;
		dreq.den   = {31'd0, len_q};
		unique case (state_q)
			ST_OFFX_DIV, ST_OFFY_DIV: begin
				dreq.start = div_pend_q;
				dreq.num   = {2'b00, prod_q};
			end
			ST_CNT_DIV: begin
				dreq.start = div_pend_q;
				dreq.num   = 66'(len_q) + 66'(minlen_q) - 66'd1;
				dreq.den   = {32'd0, minlen_q};
			end
			ST_STEPX_DIV: begin
				dreq.start = div_pend_q;
				dreq.num   = 66'(ax);
				dreq.den   = 64'(ns_q);
			end
			ST_STEPY_DIV: begin
				dreq.start = div_pend_q;
				dreq.num   = 66'(ay);
				dreq.den   = 64'(ns_q);
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			div_pend_q <= 1'b0;
			phase_q    <= '0;
		end else begin
			state_q    <= state_d;
			div_pend_q <= (state_d != state_q) &&
				(state_d == ST_OFFX_DIV || state_d == ST_OFFY_DIV ||
				 state_d == ST_CNT_DIV || state_d == ST_STEPX_DIV ||
				 state_d == ST_STEPY_DIV);
			if (state_q == ST_IDLE && start)
				phase_q <= 2'd0;
			else if (state_q == ST_SQRT && phase_q != 2'd3)
				phase_q <= phase_q + 2'd1;
		end
	end

	// Root launch once both squares are summed
	assign sq_go = (state_q == ST_SQRT) && (phase_q == 2'd2);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			sx_q <= in_beat.start_x;
			sy_q <= in_beat.start_y;
			dx_q <= 33'(in_beat.end_x) - 33'(in_beat.start_x);
			dy_q <= 33'(in_beat.end_y) - 33'(in_beat.start_y);
		end
		unique case (state_q)
			ST_SQRT: begin
				if (phase_q == 2'd0) sumsq_q <= {1'b0, mul_p};
				if (phase_q == 2'd1) sumsq_q <= sumsq_q + {1'b0, mul_p};
				if (sq_done) len_q <= sq_root;
			end
			ST_OFFX_MUL, ST_OFFY_MUL: prod_q <= mul_p;
			ST_OFFX_DIV: if (drsp.done)
				offx_q <= (dy_q[32] ^ offset_q[31]) ^ 1'b1 ?
					-34'sd0 - $signed({1'b0, drsp.quo[32:0]}) :
					$signed({1'b0, drsp.quo[32:0]});
			ST_OFFY_DIV: if (drsp.done)
				offy_q <= (dx_q[32] ^ offset_q[31]) ?
					-34'sd0 - $signed({1'b0, drsp.quo[32:0]}) :
					$signed({1'b0, drsp.quo[32:0]});
			ST_CNT_DIV: if (drsp.done) begin
				if (drsp.quo > 66'(MAX_SEGMENTS)) begin
					ns_q  <= CW'(MAX_SEGMENTS);
					cap_q <= 1'b1;
				end else begin
					ns_q  <= (ns_full == 33'd0) ? CW'(1) : ns_full[CW-1:0];
					cap_q <= 1'b0;
				end
			end
			ST_STEPX_DIV: if (drsp.done)
				stx_q <= dx_q[32] ? -34'sd0 - $signed({1'b0, drsp.quo[32:0]}) :
					$signed({1'b0, drsp.quo[32:0]});
			ST_STEPY_DIV: if (drsp.done) begin
				sty_q  <= dy_q[32] ? -34'sd0 - $signed({1'b0, drsp.quo[32:0]}) :
					$signed({1'b0, drsp.quo[32:0]});
				accx_q <= 41'(sx_q) + 41'(offx_q);
				accy_q <= 41'(sy_q) + 41'(offy_q);
				idx_q  <= '0;
			end
			ST_EMIT: begin
				accx_q <= accx_q + 41'(stx_q);
				accy_q <= accy_q + 41'(sty_q);
				idx_q  <= idx_q + CW'(1);
			end
			default: ;
		endcase
	end

	// Result beat
	function automatic logic [31:0] sat32(input logic signed [40:0] v);
		if (v > 41'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -41'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	always_comb begin
		result_valid      = 1'b0;
		result.point_x    = '0;
		result.point_y    = '0;
		result.outcome    = OUT_NORMAL;
		result.last_point = 1'b0;
		unique case (state_q)
			ST_EMIT: begin
				result_valid      = 1'b1;
				result.point_x    = sat32(accx_q);
				result.point_y    = sat32(accy_q);
				result.outcome    = cap_q ? OUT_CAPPED : OUT_NORMAL;
				result.last_point = (idx_q == ns_q);
			end
			ST_NONE: begin
				result_valid      = 1'b1;
				result.outcome    = OUT_NONE;
				result.last_point = 1'b1;
			end
			default: ;
		endcase
	end

endmodule
